// ===== rtl/core/hc3_pkg.sv =====
`timescale 1ns / 1ps

package hc3_pkg;

  localparam int LETTER_W = 5;
  localparam int KEY_LEN = 9;
  localparam int KEY_W = LETTER_W * KEY_LEN;
  localparam int ACC_W = 11;
  localparam int STEP_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [LETTER_W-1:0] MODULUS = 5'd26;

  // floor(x / 26) for x below 2048 is (x * 2521) >> 16.
  localparam logic [11:0] RECIP = 12'd2521;
  localparam int RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;

  localparam logic [STEP_W-1:0] STEP_LAST_ENTRY = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LAST_DET = 4'd2;

  typedef struct packed {
    logic              capture;
    logic              load_plain;
    logic              cof_en;
    logic              det_en;
    logic              adj_en;
    logic              sum_en;
    logic              res_en;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  function automatic logic [LETTER_W-1:0] mod26(input logic [ACC_W-1:0] x);
    logic [ACC_W+11:0] prod;
    logic [6:0]        q;
    logic [ACC_W-1:0]  qm;
    logic [ACC_W-1:0]  r;
    prod = (ACC_W+12)'(x) * (ACC_W+12)'(RECIP);
    q = 7'(prod >> RECIP_SHIFT);
    qm = ACC_W'(q) * ACC_W'(MODULUS);
    r = x - qm;
    return r[LETTER_W-1:0];
  endfunction

  function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] v);
    return (v >= MODULUS) ? v - MODULUS : v;
  endfunction

  // Multiplicative inverse mod 26; zero where none exists.
  function automatic logic [LETTER_W-1:0] inv_mod26(input logic [LETTER_W-1:0] d);
    logic [LETTER_W-1:0] r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/hill_cipher_3x3_mod26.sv =====
`timescale 1ns / 1ps

// Hill cipher on 3-letter words with a 3x3 key, all arithmetic mod 26.
// Input channel: in_valid/in_ready carry letter_a..letter_c (0..25; 26..31
// are folded mod 26). Output channel: out_valid/out_ready carry out_a..out_c
// and key_error, one result word per input word.
// Configuration: cfg_write_en with cfg_index 0 loads the nine key letters
// (row-major, letter 0 in bits 4..0), index 1 loads decrypt_mode; other
// indexes are ignored. Write only while the block is idle.
// Sequence: with the working key in place a word is captured, multiplied
// and accumulated, then reduced mod 26; a new word is taken only after the
// last has left its reduce step, and the result shows on out_valid in the
// cycle after the reduce step. The first word after reset or a key or mode
// write derives the working key: a copy in encrypt mode; in decrypt mode
// nine cofactors, three determinant steps and nine adjugates, one per cycle.
// In decrypt mode, a key whose determinant has no inverse mod 26 gives
// key_error=1 and zero letters until the next key or mode register write.
// Reset clears the key to zero, selects decrypt mode and empties the output.
// A stalled receiver holds the result register; one more input word can be
// taken and worked up to its reduce step while the earlier result waits.
module hill_cipher_3x3_mod26 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [hc3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hc3_pkg::KEY_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hc3_pkg::LETTER_W-1:0]  letter_a,
  input  logic [hc3_pkg::LETTER_W-1:0]  letter_b,
  input  logic [hc3_pkg::LETTER_W-1:0]  letter_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hc3_pkg::LETTER_W-1:0]  out_a,
  output logic [hc3_pkg::LETTER_W-1:0]  out_b,
  output logic [hc3_pkg::LETTER_W-1:0]  out_c,
  output logic                          key_error
);
  import hc3_pkg::*;

  dp_cmd_t cmd;
  logic    decrypt;

  // The controller sequences key derivation and the per-word steps.
  hc3_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .decrypt      (decrypt),
    .cmd          (cmd)
  );

  // The datapath holds the key registers, the working key and the result.
  hc3_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .letter_a     (letter_a),
    .letter_b     (letter_b),
    .letter_c     (letter_c),
    .cmd          (cmd),
    .decrypt      (decrypt),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_c        (out_c),
    .key_error    (key_error)
  );

endmodule

// ===== rtl/core/hc3_ctrl.sv =====
`timescale 1ns / 1ps

module hc3_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [hc3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          decrypt,
  output hc3_pkg::dp_cmd_t              cmd
);
  import hc3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAIN,
    ST_COF,
    ST_DET,
    ST_ADJ,
    ST_SUM,
    ST_MOD
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              key_ready;
  logic              accept;
  logic              out_free;
  logic              cfg_hit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_hit  = cfg_write_en && (cfg_index == CFG_KEY || cfg_index == CFG_MODE);

  always_comb begin
    cmd            = '0;
    cmd.step       = step;
    cmd.capture    = accept;
    cmd.load_plain = (state == ST_PLAIN);
    cmd.cof_en     = (state == ST_COF);
    cmd.det_en     = (state == ST_DET);
    cmd.adj_en     = (state == ST_ADJ);
    cmd.sum_en     = (state == ST_SUM);
    cmd.res_en     = (state == ST_MOD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      key_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.res_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            step <= '0;
            if (key_ready) begin
              state <= ST_SUM;
            end else if (decrypt) begin
              state <= ST_COF;
            end else begin
              state <= ST_PLAIN;
            end
          end
        end
        ST_PLAIN: begin
          key_ready <= 1'b1;
          state     <= ST_SUM;
        end
        ST_COF: begin
          if (step == STEP_LAST_ENTRY) begin
            step  <= '0;
            state <= ST_DET;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DET: begin
          if (step == STEP_LAST_DET) begin
            step  <= '0;
            state <= ST_ADJ;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_ADJ: begin
          if (step == STEP_LAST_ENTRY) begin
            step      <= '0;
            key_ready <= 1'b1;
            state     <= ST_SUM;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SUM: begin
          state <= ST_MOD;
        end
        ST_MOD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // User keeps writes idle-only, unchecked; a listed one forces rederivation.
      if (cfg_hit) begin
        key_ready <= 1'b0;
      end
    end
  end

  a_cfg_clears_key: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> !key_ready)
    else $error("key still marked ready after a configuration write");

  a_sum_needs_key: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> key_ready)
    else $error("multiply started before the working key was derived");

  a_adj_end_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADJ && step == STEP_LAST_ENTRY) |=> (key_ready && state == ST_SUM))
    else $error("inverse derivation did not hand over to the multiply");

endmodule

// ===== rtl/core/hc3_dp.sv =====
`timescale 1ns / 1ps

module hc3_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [hc3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hc3_pkg::KEY_W-1:0]         cfg_data,
  input  logic [hc3_pkg::LETTER_W-1:0]      letter_a,
  input  logic [hc3_pkg::LETTER_W-1:0]      letter_b,
  input  logic [hc3_pkg::LETTER_W-1:0]      letter_c,
  input  hc3_pkg::dp_cmd_t                  cmd,
  output logic                              decrypt,
  output logic [hc3_pkg::LETTER_W-1:0]      out_a,
  output logic [hc3_pkg::LETTER_W-1:0]      out_b,
  output logic [hc3_pkg::LETTER_W-1:0]      out_c,
  output logic                              key_error
);
  import hc3_pkg::*;

  logic [KEY_W-1:0]    key_letters;
  logic                decrypt_mode;
  logic [LETTER_W-1:0] kred [KEY_LEN];
  logic [LETTER_W-1:0] p    [3];
  logic [LETTER_W-1:0] cof  [KEY_LEN];
  logic [LETTER_W-1:0] wk   [KEY_LEN];
  logic [ACC_W-1:0]    sum  [3];
  logic [LETTER_W-1:0] det;
  logic                invalid;

  logic [1:0]          r;
  logic [1:0]          c;
  logic [1:0]          rr0, rr1, cc0, cc1;
  logic [STEP_W-1:0]   i0, i1, i2, i3;
  logic [STEP_W-1:0]   tidx;
  logic [ACC_W-1:0]    minor_raw;
  logic [LETTER_W-1:0] minor_mod;
  logic [LETTER_W-1:0] cof_val;
  logic [LETTER_W-1:0] det_in;
  logic [ACC_W-1:0]    det_raw;
  logic [LETTER_W-1:0] inv;
  logic [ACC_W-1:0]    adj_raw;

  assign decrypt = decrypt_mode;

  always_comb begin
    for (int i = 0; i < KEY_LEN; i++) begin
      kred[i] = red26(key_letters[i*LETTER_W +: LETTER_W]);
    end
  end

  // Row and column of the entry addressed by the step counter.
  always_comb begin
    if (cmd.step >= 4'd6) begin
      r = 2'd2;
    end else if (cmd.step >= 4'd3) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    c = 2'(cmd.step - STEP_W'(r) * 4'd3);
    rr0 = (r == 2'd0) ? 2'd1 : 2'd0;
    rr1 = (r == 2'd2) ? 2'd1 : 2'd2;
    cc0 = (c == 2'd0) ? 2'd1 : 2'd0;
    cc1 = (c == 2'd2) ? 2'd1 : 2'd2;
    i0 = STEP_W'(rr0) * 4'd3 + STEP_W'(cc0);
    i1 = STEP_W'(rr0) * 4'd3 + STEP_W'(cc1);
    i2 = STEP_W'(rr1) * 4'd3 + STEP_W'(cc0);
    i3 = STEP_W'(rr1) * 4'd3 + STEP_W'(cc1);
    tidx = STEP_W'(c) * 4'd3 + STEP_W'(r);
  end

  // One cofactor per step; adding 26*26 keeps the difference positive.
  assign minor_raw = ACC_W'(kred[i0]) * ACC_W'(kred[i3])
                   + ACC_W'(MODULUS) * ACC_W'(MODULUS)
                   - ACC_W'(kred[i1]) * ACC_W'(kred[i2]);
  assign minor_mod = mod26(minor_raw);
  assign cof_val   = ((r[0] ^ c[0]) && minor_mod != '0) ? MODULUS - minor_mod : minor_mod;

  assign det_in  = (cmd.step == '0) ? '0 : det;
  assign det_raw = ACC_W'(det_in) + ACC_W'(kred[cmd.step]) * ACC_W'(cof[cmd.step]);
  assign inv     = inv_mod26(det);
  assign adj_raw = ACC_W'(cof[tidx]) * ACC_W'(inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_letters  <= '0;
      decrypt_mode <= 1'b1;
      invalid      <= 1'b0;
    end else begin
      if (cfg_write_en && cfg_index == CFG_KEY) begin
        key_letters <= cfg_data;
      end
      if (cfg_write_en && cfg_index == CFG_MODE) begin
        decrypt_mode <= cfg_data[0];
      end
      if (cmd.load_plain) begin
        invalid <= 1'b0;
      end
      if (cmd.adj_en) begin
        invalid <= (inv == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p[0] <= red26(letter_a);
      p[1] <= red26(letter_b);
      p[2] <= red26(letter_c);
    end
    if (cmd.load_plain) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        wk[i] <= kred[i];
      end
    end
    if (cmd.cof_en) begin
      cof[cmd.step] <= cof_val;
    end
    if (cmd.det_en) begin
      det <= mod26(det_raw);
    end
    if (cmd.adj_en) begin
      wk[cmd.step] <= mod26(adj_raw);
    end
    if (cmd.sum_en) begin
      for (int j = 0; j < 3; j++) begin
        sum[j] <= ACC_W'(p[0]) * ACC_W'(wk[j])
                + ACC_W'(p[1]) * ACC_W'(wk[3+j])
                + ACC_W'(p[2]) * ACC_W'(wk[6+j]);
      end
    end
    if (cmd.res_en) begin
      out_a     <= invalid ? '0 : mod26(sum[0]);
      out_b     <= invalid ? '0 : mod26(sum[1]);
      out_c     <= invalid ? '0 : mod26(sum[2]);
      key_error <= invalid;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the 3x3 Hill cipher block.
// A queue-fed driver pushes letter words into the input channel, and a
// monitor takes result words off the output channel. Each result word is
// compared against a cipher prediction that the driver computes at the
// moment the input word is accepted.
module tb_top;
  import hc3_pkg::*;

  localparam int M26 = int'(MODULUS);
  localparam int RANDOM_WORDS = 680;
  localparam int QUIET_TAIL = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = 32;
  // Worst gap between two handshakes is a decrypt key derivation plus a full
  // sender gap and receiver stall, well below this limit.
  localparam int STALL_LIMIT = 5000;

  // Register indexes past the two real registers; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic [LETTER_W-1:0] c;
  } letter_word_t;

  typedef struct packed {
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic [LETTER_W-1:0] c;
    logic                err;
  } cipher_word_t;

  // Every input of the block starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LETTER_W-1:0]  letter_a = '0;
  logic [LETTER_W-1:0]  letter_b = '0;
  logic [LETTER_W-1:0]  letter_c = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LETTER_W-1:0]  out_a;
  logic [LETTER_W-1:0]  out_b;
  logic [LETTER_W-1:0]  out_c;
  logic                 key_error;

  hill_cipher_3x3_mod26 i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .letter_a     (letter_a),
    .letter_b     (letter_b),
    .letter_c     (letter_c),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_c        (out_c),
    .key_error    (key_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words waiting to be sent, and result words still owed by the block.
  letter_word_t pending_words[$];
  cipher_word_t owed_results[$];

  // Shadow of the configuration registers and of the derived working key.
  logic [KEY_W-1:0] key_shadow = '0;
  logic             decrypt_shadow = 1'b1;
  int               working_key[9];
  bit               key_derived = 1'b0;
  bit               key_singular = 1'b0;

  // Once set, neither side starts a new idle burst.
  bit quiet = 1'b0;

  int mismatches = 0;
  int words_sent = 0;
  int results_checked = 0;
  int key_error_results = 0;
  int reg_writes = 0;
  int derivations = 0;
  int decrypt_derivations = 0;

  // Key letter idx, folded into 0..25 the way the block reads it.
  function automatic int key_letter(input logic [KEY_W-1:0] key, input int idx);
    int v;
    v = int'(key[idx*LETTER_W +: LETTER_W]);
    return v % M26;
  endfunction

  // Signed cofactor of entry (r, c), reduced into 0..25.
  function automatic int cofactor26(input logic [KEY_W-1:0] key, input int r, input int c);
    int r0, r1, c0, c1, m;
    r0 = (r == 0) ? 1 : 0;
    r1 = (r == 2) ? 1 : 2;
    c0 = (c == 0) ? 1 : 0;
    c1 = (c == 2) ? 1 : 2;
    m = key_letter(key, r0*3 + c0) * key_letter(key, r1*3 + c1)
      - key_letter(key, r0*3 + c1) * key_letter(key, r1*3 + c0);
    m = ((m % M26) + M26) % M26;
    if (((r + c) % 2) != 0) m = (M26 - m) % M26;
    return m;
  endfunction

  function automatic int det26(input logic [KEY_W-1:0] key);
    int d;
    d = 0;
    for (int c = 0; c < 3; c++) d = (d + key_letter(key, c) * cofactor26(key, 0, c)) % M26;
    return d;
  endfunction

  // Zero when the determinant shares a factor with 26.
  function automatic int inverse26(input int d);
    int inv;
    inv = 0;
    for (int i = M26 - 1; i >= 1; i--) if ((d * i) % M26 == 1) inv = i;
    return inv;
  endfunction

  // Builds the working key from the shadow registers: the key itself when
  // encrypting, its inverse (adjugate times inverse determinant) when decrypting.
  function automatic void derive_working_key();
    int inv;
    key_singular = 1'b0;
    derivations++;
    if (!decrypt_shadow) begin
      for (int i = 0; i < 9; i++) working_key[i] = key_letter(key_shadow, i);
    end else begin
      decrypt_derivations++;
      inv = inverse26(det26(key_shadow));
      if (inv == 0) begin
        key_singular = 1'b1;
        for (int i = 0; i < 9; i++) working_key[i] = 0;
      end else begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            working_key[r*3 + c] = (cofactor26(key_shadow, c, r) * inv) % M26;
      end
    end
    key_derived = 1'b1;
  endfunction

  // Result word for one accepted letter word; derives the key on first use.
  function automatic cipher_word_t encipher_word(input letter_word_t w);
    cipher_word_t res;
    int p0, p1, p2;
    int s[3];
    res = '0;
    p0 = int'(w.a) % M26;
    p1 = int'(w.b) % M26;
    p2 = int'(w.c) % M26;
    if (!key_derived) derive_working_key();
    if (key_singular) begin
      res.err = 1'b1;
    end else begin
      for (int j = 0; j < 3; j++)
        s[j] = (p0 * working_key[j] + p1 * working_key[3 + j] + p2 * working_key[6 + j]) % M26;
      res.a = LETTER_W'(s[0]);
      res.b = LETTER_W'(s[1]);
      res.c = LETTER_W'(s[2]);
    end
    return res;
  endfunction

  // Driver. A word is launched whenever the channel is free; now and then a
  // burst of idle cycles is inserted before the next launch.
  int           send_gap = 0;
  letter_word_t launch_word;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        owed_results.push_back(encipher_word(letter_word_t'{letter_a, letter_b, letter_c}));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          launch_word = pending_words.pop_front();
          letter_a <= launch_word.a;
          letter_b <= launch_word.b;
          letter_c <= launch_word.c;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. It checks each accepted result word against the oldest owed
  // one, and holds off the output channel in random bursts.
  int           recv_stall = 0;
  cipher_word_t got_word;
  cipher_word_t owed_word;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_word = '{out_a, out_b, out_c, key_error};
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word a=%0d b=%0d c=%0d err=%0d arrived with none owed",
                     $realtime, out_a, out_b, out_c, key_error);
        end else begin
          owed_word = owed_results.pop_front();
          results_checked++;
          if (got_word.err) key_error_results++;
          if (got_word.a !== owed_word.a || got_word.b !== owed_word.b ||
              got_word.c !== owed_word.c || got_word.err !== owed_word.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d expected a=%0d b=%0d c=%0d err=%0d, got a=%0d b=%0d c=%0d err=%0d",
                       $realtime, results_checked, owed_word.a, owed_word.b, owed_word.c,
                       owed_word.err, got_word.a, got_word.b, got_word.c, got_word.err);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] raw_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  // Key from a string of nine capital letters, entry 0 first.
  function automatic logic [KEY_W-1:0] key_from_text(input string s);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int i = 0; i < 9; i++) key[i*LETTER_W +: LETTER_W] = LETTER_W'(s[i] - "A");
    return key;
  endfunction

  // Random key. When decrypting, most keys are retried until invertible so
  // that the multiply path sees plenty of real inverse keys.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    key = '0;
    if ($urandom_range(0, 7) == 0) return raw_bits();
    for (int t = 0; t < 30; t++) begin
      for (int i = 0; i < 9; i++) key[i*LETTER_W +: LETTER_W] = LETTER_W'($urandom_range(0, 25));
      if (!decrypt_shadow || $urandom_range(0, 4) == 0 || inverse26(det26(key)) != 0)
        return key;
    end
    return key;
  endfunction

  function automatic logic [LETTER_W-1:0] random_letter();
    if ($urandom_range(0, 7) == 0) return LETTER_W'($urandom_range(26, 31));
    return LETTER_W'($urandom_range(0, 25));
  endfunction

  // One register write. The shadow follows at once; no word is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_KEY: begin
        key_shadow = val;
        key_derived = 1'b0;
        key_singular = 1'b0;
      end
      CFG_MODE: begin
        decrypt_shadow = val[0];
        key_derived = 1'b0;
        key_singular = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Mode write with random upper data bits, which the block must drop.
  task automatic write_mode(input logic decrypt);
    logic [KEY_W-1:0] val;
    val = raw_bits();
    val[0] = decrypt;
    write_reg(CFG_MODE, val);
  endtask

  task automatic queue_word(input int a, input int b, input int c);
    pending_words.push_back(letter_word_t'{LETTER_W'(a), LETTER_W'(b), LETTER_W'(c)});
  endtask

  // The sender holds back until every queued word is sent and every owed
  // result is back; then the block is idle and may take register writes.
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_sent;
    int n;
    random_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset: decrypt mode with an all-zero key, which has no
    // inverse, so both words must come back as key errors.
    queue_word(0, 0, 0);
    queue_word(31, 31, 31);
    drain();

    // A textbook invertible key, decrypted. Letter extremes, values above 25
    // that fold, and the unit vectors that read out single working key rows.
    write_reg(CFG_KEY, key_from_text("GYBNQKURP"));
    queue_word(0, 0, 0);
    queue_word(25, 25, 25);
    queue_word(26, 27, 28);
    queue_word(31, 30, 29);
    queue_word(1, 0, 0);
    queue_word(0, 1, 0);
    queue_word(0, 0, 1);
    drain();

    // Writes to unused indexes change nothing.
    write_reg(CFG_SPARE_2, raw_bits());
    write_reg(CFG_SPARE_3, raw_bits());
    queue_word(19, 7, 3);
    queue_word(0, 25, 12);
    drain();

    // Encrypt mode uses the key directly and never flags an error.
    write_mode(1'b0);
    queue_word(25, 0, 31);
    queue_word(13, 26, 7);
    queue_word(25, 25, 25);
    drain();

    // All key bits set: every key letter is 31, which folds to 5.
    write_reg(CFG_KEY, {KEY_W{1'b1}});
    queue_word(31, 31, 31);
    queue_word(1, 2, 3);
    drain();

    // The same key is singular, so decrypting it must flag an error.
    write_mode(1'b1);
    queue_word(4, 5, 6);
    drain();

    // An even determinant and a determinant of 13 both have no inverse.
    write_reg(CFG_KEY, key_from_text("CAAACAAAC"));
    queue_word(1, 1, 1);
    drain();
    write_reg(CFG_KEY, key_from_text("NAAABAAAB"));
    queue_word(2, 3, 4);
    drain();

    // The identity is its own inverse.
    write_reg(CFG_KEY, key_from_text("BAAABAAAB"));
    queue_word(7, 8, 9);
    drain();

    // A zero key in encrypt mode maps every word to zero.
    write_mode(1'b0);
    write_reg(CFG_KEY, '0);
    queue_word(25, 25, 25);
    drain();

    // Random phases: a fresh setting, then a burst of random words. Most
    // bursts are short so that the first-word key derivation is hit often.
    while (random_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 1) == 0) write_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_KEY, random_key());
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, raw_bits());
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(4, 30);
      if (random_sent >= RANDOM_WORDS - QUIET_TAIL) quiet = 1'b1;
      for (int i = 0; i < n; i++)
        queue_word(random_letter(), random_letter(), random_letter());
      random_sent += n;
      drain();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $display("%0d result words never arrived", owed_results.size());
      mismatches += owed_results.size();
    end

    $display("Sent %0d words and checked %0d results (%0d with key_error) across %0d register writes.",
             words_sent, results_checked, key_error_results, reg_writes);
    $display("The working key was derived %0d times, %0d of them as an inverse for decryption.",
             derivations, decrypt_derivations);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
